// File: hw/rtl/pdh_pkg.sv
// Package for the presence detector with hold-off.
// Sizes, state codes and the configuration/result types shared by all modules.
// No dependencies.
`default_nettype none

package pdh_pkg;

    localparam int NUM_SENSORS = 5;
    localparam int COUNT_WIDTH = 16;

    localparam int LEVEL_W  = 5;
    localparam int TICKS_W  = 16;
    localparam int CIDX_W   = 8;
    localparam int CDATA_W  = 16;
    localparam int CMP_W    = (COUNT_WIDTH > TICKS_W) ? COUNT_WIDTH : TICKS_W;

    localparam logic [LEVEL_W-1:0] SENSOR_MASK =
        (NUM_SENSORS >= LEVEL_W) ? {LEVEL_W{1'b1}}
                                 : LEVEL_W'((64'd1 << NUM_SENSORS) - 64'd1);

    localparam logic [COUNT_WIDTH-1:0] COUNT_MAX = {COUNT_WIDTH{1'b1}};

    // register indexes
    localparam logic [CIDX_W-1:0] REG_SENSOR_ENABLE = 8'd0;
    localparam logic [CIDX_W-1:0] REG_ACTIVE_LEVEL  = 8'd1;
    localparam logic [CIDX_W-1:0] REG_WAIT_TICKS    = 8'd2;
    localparam logic [CIDX_W-1:0] REG_RELEASE_TICKS = 8'd3;

    // per-beat state codes
    localparam logic [1:0] ST_IDLE  = 2'd0;
    localparam logic [1:0] ST_NEW   = 2'd1;
    localparam logic [1:0] ST_TRACK = 2'd2;
    localparam logic [1:0] ST_REL   = 2'd3;

    typedef struct packed {
        logic [LEVEL_W-1:0] sensor_enable;
        logic               active_level;
        logic [TICKS_W-1:0] wait_ticks;
        logic [TICKS_W-1:0] release_ticks;
    } cfg_t;

    typedef struct packed {
        logic [LEVEL_W-1:0] detect_mask;
        logic               unknown_flag;
        logic [1:0]         state_code;
    } result_t;

endpackage

`default_nettype wire

// File: hw/rtl/pdh_cfg.sv
// Configuration register bank for the presence detector.
// Depends on pdh_pkg.
`default_nettype none

module pdh_cfg (
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  wr_en,
    input  wire logic [pdh_pkg::CIDX_W-1:0]  wr_index,
    input  wire logic [pdh_pkg::CDATA_W-1:0] wr_data,
    output pdh_pkg::cfg_t              cfg
);
    import pdh_pkg::*;

    cfg_t cfg_reg;
    cfg_t cfg_next;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (wr_en)
        begin
            case (wr_index)
                REG_SENSOR_ENABLE: cfg_next.sensor_enable = wr_data[LEVEL_W-1:0];
                REG_ACTIVE_LEVEL:  cfg_next.active_level  = wr_data[0];
                REG_WAIT_TICKS:    cfg_next.wait_ticks    = wr_data[TICKS_W-1:0];
                REG_RELEASE_TICKS: cfg_next.release_ticks = wr_data[TICKS_W-1:0];
                default:           cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.sensor_enable <= {LEVEL_W{1'b1}};
            cfg_reg.active_level  <= 1'b1;
            cfg_reg.wait_ticks    <= '0;
            cfg_reg.release_ticks <= '0;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

`default_nettype wire

// File: hw/rtl/pdh_core.sv
// Detection state machine with debounce and release counters.
// Computes one result per step from registered levels; depends on pdh_pkg.
`default_nettype none

module pdh_core (
    input  wire logic                    clk,
    input  wire logic                    rst_n,
    input  wire logic                    step,
    input  wire logic [pdh_pkg::LEVEL_W-1:0] levels,
    input  wire pdh_pkg::cfg_t           cfg,
    output pdh_pkg::result_t             result,
    output logic                         tracking
);
    import pdh_pkg::*;

    typedef enum logic {PH_IDLE, PH_TRACK} phase_t;

    phase_t                 phase_reg, phase_next;
    logic [COUNT_WIDTH-1:0] detect_count_reg, detect_count_next;
    logic [COUNT_WIDTH-1:0] release_count_reg, release_count_next;

    logic [LEVEL_W-1:0]     hit;
    logic [LEVEL_W-1:0]     det;
    logic [TICKS_W-1:0]     rel_m1;
    logic [COUNT_WIDTH-1:0] reload;
    logic [1:0]             tick;
    logic                   is_track;

    assign is_track = (phase_reg == PH_TRACK);

    always_comb
    begin
        hit    = cfg.active_level ? levels : ~levels;
        det    = hit & cfg.sensor_enable & SENSOR_MASK;
        rel_m1 = (cfg.release_ticks == '0) ? '0 : cfg.release_ticks - 1'b1;
        if (CMP_W'(rel_m1) > CMP_W'(COUNT_MAX))
            reload = COUNT_MAX;
        else
            reload = COUNT_WIDTH'(rel_m1);

        tick               = is_track ? ST_TRACK : ST_IDLE;
        detect_count_next  = detect_count_reg;
        release_count_next = release_count_reg;

        if (det != '0)
        begin
            if (!is_track)
            begin
                if (CMP_W'(detect_count_reg) >= CMP_W'(cfg.wait_ticks))
                begin
                    tick               = ST_NEW;
                    release_count_next = reload;
                end
                else if (detect_count_reg != COUNT_MAX)
                begin
                    detect_count_next = detect_count_reg + 1'b1;
                end
            end
            else
            begin
                release_count_next = reload;
            end
        end
        else
        begin
            if (release_count_reg == '0)
            begin
                if (is_track)
                    tick = ST_REL;
            end
            else
            begin
                release_count_next = release_count_reg - 1'b1;
            end
            detect_count_next = '0;
        end

        if (tick == ST_NEW || tick == ST_TRACK)
        begin
            result.detect_mask  = det;
            result.unknown_flag = (det == '0);
            phase_next          = PH_TRACK;
        end
        else
        begin
            result.detect_mask  = '0;
            result.unknown_flag = 1'b0;
            phase_next          = PH_IDLE;
        end
        result.state_code = tick;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg         <= PH_IDLE;
            detect_count_reg  <= '0;
            release_count_reg <= '0;
        end
        else if (step)
        begin
            phase_reg         <= phase_next;
            detect_count_reg  <= detect_count_next;
            release_count_reg <= release_count_next;
        end
    end

    assign tracking = is_track;

endmodule

`default_nettype wire

// File: hw/rtl/presence_detect_with_holdoff.sv
// Top level of the presence detector with hold-off.
// Input beat register, result register and handshakes; uses pdh_cfg, pdh_core, pdh_pkg.
//
// Usage:
//   s_* carries one sample beat per tick: s_tdata[4:0] sensor levels.
//   m_* returns one result beat per sample: m_tdata[4:0] detect mask,
//   m_tuser[0] unknown flag, m_tuser[2:1] state code (idle, new, tracking,
//   released).
//   cfg_* writes a register by index (0 sensor enable, 1 active level,
//   2 wait ticks, 3 release ticks); always ready, other indexes are dropped.
//   Write registers only while no sample is in flight.
// Path: a sample is accepted into the input register, then the state machine
//   step moves it into the result register, which drives m_*.
// Throughput: one beat per cycle while no result is held; the state machine and
//   both counters update in the same cycle as a beat moves to the result register.
// Reset: counters cleared, state idle, registers at defaults, no beats held.
// Stall: a held result blocks the stage behind it; with both stages full,
//   s_tready drops until m_tready returns.
`default_nettype none

module presence_detect_with_holdoff (
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       s_tvalid,
    output logic            s_tready,
    input  wire logic [7:0] s_tdata,   // [4:0] sensor_levels
    output logic            m_tvalid,
    input  wire logic       m_tready,
    output logic [7:0]      m_tdata,   // [4:0] detect_mask
    output logic [2:0]      m_tuser,   // [0] unknown_flag, [2:1] state_code
    input  wire logic       cfg_valid,
    output logic            cfg_ready,
    input  wire logic [pdh_pkg::CIDX_W-1:0]  cfg_index,
    input  wire logic [pdh_pkg::CDATA_W-1:0] cfg_data
);
    import pdh_pkg::*;

    cfg_t               cfg;
    result_t            result;
    logic               tracking;

    logic               in_valid_reg;
    logic [LEVEL_W-1:0] in_levels_reg;
    logic               out_valid_reg;
    result_t            out_reg;

    logic               out_free;
    logic               step;
    logic               s_fire;

    assign cfg_ready = 1'b1;
    assign out_free  = !out_valid_reg || m_tready;
    assign step      = in_valid_reg && out_free;
    assign s_tready  = !in_valid_reg || out_free;
    assign s_fire    = s_tvalid && s_tready;

    pdh_cfg u_cfg (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr_en    (cfg_valid && cfg_ready),
        .wr_index (cfg_index),
        .wr_data  (cfg_data),
        .cfg      (cfg)
    );

    pdh_core u_core (
        .clk      (clk),
        .rst_n    (rst_n),
        .step     (step),
        .levels   (in_levels_reg),
        .cfg      (cfg),
        .result   (result),
        .tracking (tracking)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (s_fire)
                in_valid_reg <= 1'b1;
            else if (step)
                in_valid_reg <= 1'b0;

            if (step)
                out_valid_reg <= 1'b1;
            else if (m_tready)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_fire)
            in_levels_reg <= s_tdata[LEVEL_W-1:0];
        if (step)
            out_reg <= result;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {{(8 - LEVEL_W){1'b0}}, out_reg.detect_mask};
    assign m_tuser  = {out_reg.state_code, out_reg.unknown_flag};

    a_unknown_empty: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tuser[0] |-> m_tdata[4:0] == '0)
        else $error("unknown flag with non-empty mask");

    a_release_quiet: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && (m_tuser[2:1] == ST_REL || m_tuser[2:1] == ST_IDLE)
        |-> m_tdata[4:0] == '0 && !m_tuser[0])
        else $error("idle or release beat carries detection data");

    a_new_enters_track: assert property (@(posedge clk) disable iff (!rst_n)
        step && (result.state_code == ST_NEW || result.state_code == ST_TRACK)
        |=> tracking)
        else $error("detection beat did not leave the block tracking");

    a_stall_only_full: assert property (@(posedge clk) disable iff (!rst_n)
        !s_tready |-> in_valid_reg && m_tvalid && !m_tready)
        else $error("input stalled without a full pipeline");

endmodule

`default_nettype wire
